// ----- rtl/vaps_pkg.sv -----
`default_nettype none
package vaps_pkg;
    localparam int VOICES  = 32;
    localparam int BUFFERS = 64;
    localparam int VIDX_W  = $clog2(VOICES);
    localparam int BUF_W   = $clog2(BUFFERS);
    localparam int CNT_W   = 6;

    localparam logic [15:0] Q15_ONE        = 16'd32768;
    localparam logic [9:0]  NEVER_STEAL    = 10'd1000;
    localparam logic [9:0]  MUSIC_PRIORITY = 10'd100;
    localparam logic [15:0] MASTER_RST     = 16'd32768;
    localparam logic [15:0] MUSIC_RST      = 16'd22938;
    localparam logic [15:0] EFFECTS_RST    = 16'd26214;

    typedef enum logic [2:0] {
        OP_PLAY_FX    = 3'd0,
        OP_PLAY_MUSIC = 3'd1,
        OP_STOP_ID    = 3'd2,
        OP_STOP_ALL   = 3'd3,
        OP_FINISHED   = 3'd4,
        OP_QUERY      = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_NO_VOICE = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_MASTER  = 3'd0,
        CFG_MUSIC   = 3'd1,
        CFG_EFFECTS = 3'd2,
        CFG_SND_EN  = 3'd3,
        CFG_MUS_EN  = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_LAST,
        S_DECIDE,
        S_GAIN,
        S_FIN_RD,
        S_FIN_DEC
    } t_state;

    typedef struct packed {
        logic        active;
        logic        finished;
        logic        looping;
        logic [9:0]  prio;
        logic [15:0] id;
    } t_voice;

    function automatic logic [15:0] sat_q15(input logic [15:0] v);
        return (v > Q15_ONE) ? Q15_ONE : v;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/voice_allocator_priority_steal.sv -----
// channel  | signals                                        | direction
// command  | i_start, o_busy, i_operation .. i_finished_voice | in
// result   | o_done, o_status .. o_active_count            | out
// config   | i_cfg_we, i_cfg_idx, i_cfg_wdata              | in
// an item is taken when i_start is high and o_busy is low
// play, stop id and query scan the voice table, one entry per cycle
// play then runs the shared gain multiplier: master and effects, with music gain first for music
// stop all sweeps the table; a finished event reads only the entry it names
// after reset the table is cleared with o_busy high
// o_done marks a result for one cycle; the receiver cannot stall
`default_nettype none
module voice_allocator_priority_steal (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_operation,
    input  wire logic [15:0] i_volume,
    input  wire logic        i_looping,
    input  wire logic [9:0]  i_priority_req,
    input  wire logic [15:0] i_target_id,
    input  wire logic [4:0]  i_finished_voice,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [15:0]      o_new_id,
    output logic [4:0]       o_voice_index,
    output logic [5:0]       o_buffer_index,
    output logic [15:0]      o_gain,
    output logic             o_is_playing,
    output logic [15:0]      o_completed_id,
    output logic [5:0]       o_active_count
);
    import vaps_pkg::*;

    t_voice mem [VOICES];
    t_voice r_rdata;

    logic [15:0] r_master, r_music, r_effects;
    logic        r_snd_en, r_mus_en;

    t_state      r_state, n_state;
    logic [2:0]  r_op;
    logic [15:0] r_volume, r_target;
    logic        r_looping;
    logic [9:0]  r_prio;
    logic [4:0]  r_fin;
    logic        r_report;
    logic        r_done;

    logic [VIDX_W-1:0] r_addr;
    logic              r_rd_vld;
    logic [VIDX_W-1:0] r_rd_idx;
    logic              r_free_found, r_fin_found, r_best_found, r_match_found;
    logic [VIDX_W-1:0] r_free_idx, r_fin_idx, r_best_idx, r_match_idx, r_vidx;
    logic [9:0]        r_best_prio;
    logic              r_match_fin;
    logic              r_tier_free;

    logic [15:0]      r_next_id;
    logic [BUF_W-1:0] r_next_buf;
    logic [CNT_W-1:0] r_total, n_total;

    logic              mem_we;
    logic [VIDX_W-1:0] mem_waddr, rd_addr;
    t_voice            mem_wdata;

    logic        res_vld;
    logic [1:0]  n_status;
    logic [15:0] n_new_id, n_done_id;
    logic [4:0]  n_vidx;
    logic [5:0]  n_bidx;
    logic [15:0] n_gain;
    logic        n_playing;
    logic        id_adv;
    logic        g_start, g_done;
    logic [15:0] g_gain;
    logic        accept;

    assign accept = i_start && (r_state == S_IDLE);

    vaps_gain u_gain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (g_start),
        .i_music      (r_op == OP_PLAY_MUSIC),
        .i_volume     (r_volume),
        .i_master     (r_master),
        .i_music_gain (r_music),
        .i_effects    (r_effects),
        .o_done       (g_done),
        .o_gain       (g_gain)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        mem_we = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        rd_addr = r_addr;
        res_vld = 1'b0;
        n_status = ST_OK;
        n_new_id = '0;
        n_done_id = '0;
        n_vidx = '0;
        n_bidx = '0;
        n_gain = '0;
        n_playing = 1'b0;
        n_total = r_total;
        id_adv = 1'b0;
        g_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_operation)
                        OP_PLAY_FX, OP_PLAY_MUSIC: begin
                            if (!r_snd_en || (i_operation == OP_PLAY_MUSIC && !r_mus_en)) begin
                                res_vld = 1'b1;
                                n_status = ST_REFUSED;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_STOP_ID, OP_QUERY: n_state = S_SCAN;
                        OP_STOP_ALL: n_state = S_CLEAR;
                        OP_FINISHED: n_state = S_FIN_RD;
                        default: res_vld = 1'b1;
                    endcase
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                n_total = '0;
                if (r_addr == VIDX_W'(VOICES - 1)) begin
                    n_state = S_IDLE;
                    res_vld = r_report;
                end
            end
            S_SCAN: begin
                if (r_addr == VIDX_W'(VOICES - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_DECIDE;
            S_DECIDE: begin
                mem_waddr = r_match_idx;
                if (r_op == OP_STOP_ID || r_op == OP_QUERY) begin
                    res_vld = 1'b1;
                    n_state = S_IDLE;
                    if (!r_match_found) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        n_vidx = 5'(r_match_idx);
                        if (r_op == OP_QUERY) begin
                            n_playing = !r_match_fin;
                        end else begin
                            mem_we = 1'b1;
                            n_total = (r_total != '0) ? r_total - 1'b1 : r_total;
                        end
                    end
                end else if (!r_free_found && !r_fin_found && !r_best_found) begin
                    res_vld = 1'b1;
                    n_state = S_IDLE;
                    n_status = ST_NO_VOICE;
                end else begin
                    g_start = 1'b1;
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                if (g_done) begin
                    mem_we = 1'b1;
                    mem_waddr = r_vidx;
                    mem_wdata.active = 1'b1;
                    mem_wdata.looping = r_looping;
                    mem_wdata.prio = (r_op == OP_PLAY_MUSIC) ? MUSIC_PRIORITY : r_prio;
                    mem_wdata.id = r_next_id;
                    res_vld = 1'b1;
                    id_adv = 1'b1;
                    n_state = S_IDLE;
                    n_new_id = r_next_id;
                    n_vidx = 5'(r_vidx);
                    n_bidx = 6'(r_next_buf);
                    n_gain = g_gain;
                    n_total = r_tier_free ? r_total + 1'b1 : r_total;
                end
            end
            S_FIN_RD: begin
                rd_addr = VIDX_W'(r_fin);
                n_state = S_FIN_DEC;
            end
            S_FIN_DEC: begin
                res_vld = 1'b1;
                n_state = S_IDLE;
                mem_waddr = VIDX_W'(r_fin);
                if ({27'd0, r_fin} >= VOICES || !r_rdata.active) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    mem_we = 1'b1;
                    n_vidx = r_fin;
                    if (r_rdata.looping) begin
                        mem_wdata = r_rdata;
                        mem_wdata.finished = 1'b1;
                    end else begin
                        n_done_id = r_rdata.id;
                        n_total = (r_total != '0) ? r_total - 1'b1 : r_total;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr <= '0;
            r_report <= 1'b0;
            r_rd_vld <= 1'b0;
            r_done <= 1'b0;
            r_total <= '0;
            r_next_id <= 16'd1;
            r_next_buf <= '0;
            r_master <= MASTER_RST;
            r_music <= MUSIC_RST;
            r_effects <= EFFECTS_RST;
            r_snd_en <= 1'b1;
            r_mus_en <= 1'b1;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_done <= res_vld;
            r_rd_vld <= (r_state == S_SCAN);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MASTER:  r_master <= i_cfg_wdata;
                    CFG_MUSIC:   r_music <= i_cfg_wdata;
                    CFG_EFFECTS: r_effects <= i_cfg_wdata;
                    CFG_SND_EN:  r_snd_en <= i_cfg_wdata[0];
                    CFG_MUS_EN:  r_mus_en <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_addr <= '0;
                r_report <= 1'b1;
            end else if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_addr <= r_addr + 1'b1;
            end
            if (id_adv) begin
                r_next_id <= (r_next_id == 16'hFFFF) ? 16'd1 : r_next_id + 16'd1;
                r_next_buf <= (r_next_buf == BUF_W'(BUFFERS - 1)) ? '0 : r_next_buf + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_operation;
            r_volume <= i_volume;
            r_looping <= i_looping;
            r_prio <= i_priority_req;
            r_target <= i_target_id;
            r_fin <= i_finished_voice;
            r_free_found <= 1'b0;
            r_fin_found <= 1'b0;
            r_best_found <= 1'b0;
            r_match_found <= 1'b0;
            r_best_prio <= NEVER_STEAL;
        end else if (r_rd_vld) begin
            if (!r_rdata.active && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (r_rdata.finished && !r_fin_found) begin
                r_fin_found <= 1'b1;
                r_fin_idx <= r_rd_idx;
            end
            if (r_rdata.prio < r_best_prio) begin
                r_best_found <= 1'b1;
                r_best_prio <= r_rdata.prio;
                r_best_idx <= r_rd_idx;
            end
            if (r_rdata.active && r_target != '0 && r_rdata.id == r_target
                    && !r_match_found) begin
                r_match_found <= 1'b1;
                r_match_idx <= r_rd_idx;
                r_match_fin <= r_rdata.finished;
            end
        end
        if (r_state == S_SCAN) begin
            r_rd_idx <= r_addr;
        end
        if (r_state == S_DECIDE) begin
            r_tier_free <= r_free_found;
            r_vidx <= r_free_found ? r_free_idx : (r_fin_found ? r_fin_idx : r_best_idx);
        end
        if (res_vld) begin
            o_status <= n_status;
            o_new_id <= n_new_id;
            o_voice_index <= n_vidx;
            o_buffer_index <= n_bidx;
            o_gain <= n_gain;
            o_is_playing <= n_playing;
            o_completed_id <= n_done_id;
            o_active_count <= 6'(n_total);
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {26'd0, r_total} <= VOICES)
        else $error("active total above voice count");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !res_vld |=> o_busy)
        else $error("accepted item did not raise busy");
    a_gain_only_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_done |-> r_state == S_GAIN)
        else $error("gain result outside play");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done || $past(r_state) == S_IDLE)
        else $error("result strobe repeated");
endmodule
`default_nettype wire

// ----- rtl/vaps_gain.sv -----
`default_nettype none
module vaps_gain (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_music,
    input  wire logic [15:0] i_volume,
    input  wire logic [15:0] i_master,
    input  wire logic [15:0] i_music_gain,
    input  wire logic [15:0] i_effects,
    output logic             o_done,
    output logic [15:0]      o_gain
);
    import vaps_pkg::*;

    logic        r_busy;
    logic        r_phase;
    logic [1:0]  r_step;
    logic [15:0] r_acc;
    logic [31:0] r_prod;
    logic        r_done;
    logic [15:0] operand;
    logic [31:0] rounded;

    always_comb begin
        case (r_step)
            2'd0:    operand = sat_q15(i_music_gain);
            2'd1:    operand = sat_q15(i_master);
            default: operand = sat_q15(i_effects);
        endcase
    end

    assign rounded = r_prod + 32'd16384;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_phase <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_phase <= 1'b0;
                r_step <= i_music ? 2'd0 : 2'd1;
                r_acc <= sat_q15(i_volume);
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_prod <= r_acc * operand;
                    r_phase <= 1'b1;
                end else begin
                    r_acc <= rounded[30:15];
                    r_phase <= 1'b0;
                    if (r_step == 2'd2) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gain = r_acc;
endmodule
`default_nettype wire

// ----- tb/voice_allocator_priority_steal_test.sv -----
`timescale 1ns / 100ps
module voice_allocator_priority_steal_test;
    import vaps_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 70;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_id;
        logic [4:0]  vidx;
        logic [5:0]  bidx;
        logic [15:0] gain;
        logic        playing;
        logic [15:0] done_id;
        logic [5:0]  count;
    } t_outcome;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] vol;
        logic        loop;
        logic [9:0]  prio;
        logic [15:0] tgt;
        logic [4:0]  fin;
        bit          typed;
        t_outcome    want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_operation = '0;
    logic [15:0] i_volume = '0;
    logic        i_looping = 1'b0;
    logic [9:0]  i_priority_req = '0;
    logic [15:0] i_target_id = '0;
    logic [4:0]  i_finished_voice = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_busy, o_done, o_is_playing;
    logic [1:0]  o_status;
    logic [15:0] o_new_id, o_gain, o_completed_id;
    logic [4:0]  o_voice_index;
    logic [5:0]  o_buffer_index, o_active_count;

    voice_allocator_priority_steal dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the voice table and settings
    logic        vox_active [VOICES];
    logic        vox_finished [VOICES];
    logic        vox_looping [VOICES];
    logic [9:0]  vox_prio [VOICES];
    logic [15:0] vox_id [VOICES];
    logic [15:0] id_counter;
    logic [5:0]  buf_counter;
    logic [5:0]  live_voices;
    logic [15:0] master_g, music_g, effects_g;
    logic        snd_en, mus_en;

    t_outcome pending_results [$];
    t_stim_row dir_tab [$];
    bit failed = 0;
    int quiet_cycles = 0;

    function automatic logic [31:0] clamp_q15(input logic [15:0] v);
        return (v > 16'd32768) ? 32'd32768 : {16'd0, v};
    endfunction

    function automatic logic [31:0] q15_mul(input logic [31:0] a, input logic [31:0] b);
        return (a * b + 32'd16384) >> 15;
    endfunction

    function automatic void release_voice(input int v);
        vox_active[v] = 1'b0;
        vox_finished[v] = 1'b0;
        vox_id[v] = '0;
        if (live_voices > 0) live_voices--;
    endfunction

    function automatic int choose_voice();
        int best;
        logic [9:0] lowest;
        best = -1;
        lowest = NEVER_STEAL;
        for (int v = 0; v < VOICES; v++) if (!vox_active[v]) return v;
        for (int v = 0; v < VOICES; v++) begin
            if (vox_finished[v]) begin
                release_voice(v);
                return v;
            end
        end
        for (int v = 0; v < VOICES; v++) begin
            if (vox_prio[v] < lowest) begin
                lowest = vox_prio[v];
                best = v;
            end
        end
        if (best >= 0) release_voice(best);
        return best;
    endfunction

    function automatic int lookup_id(input logic [15:0] id);
        if (id == 0) return -1;
        for (int v = 0; v < VOICES; v++) if (vox_active[v] && vox_id[v] == id) return v;
        return -1;
    endfunction

    function automatic t_outcome allocate_and_predict(input logic [2:0] op,
            input logic [15:0] vol_in, input logic loop, input logic [9:0] prio_in,
            input logic [15:0] tgt, input logic [4:0] fin);
        t_outcome r;
        int v;
        logic [31:0] vol;
        logic [9:0] prio;
        r = '0;
        vol = clamp_q15(vol_in);
        prio = prio_in;
        case (op)
            OP_PLAY_FX, OP_PLAY_MUSIC: begin
                if (!snd_en || (op == OP_PLAY_MUSIC && !mus_en)) begin
                    r.status = ST_REFUSED;
                end else begin
                    v = choose_voice();
                    if (v < 0) begin
                        r.status = ST_NO_VOICE;
                    end else begin
                        if (op == OP_PLAY_MUSIC) begin
                            vol = q15_mul(vol, clamp_q15(music_g));
                            prio = MUSIC_PRIORITY;
                        end
                        r.gain = 16'(q15_mul(q15_mul(vol, clamp_q15(master_g)),
                                             clamp_q15(effects_g)));
                        r.bidx = buf_counter;
                        buf_counter = buf_counter + 6'd1;
                        r.new_id = id_counter;
                        id_counter = (id_counter == 16'hFFFF) ? 16'd1 : id_counter + 16'd1;
                        vox_active[v] = 1'b1;
                        vox_finished[v] = 1'b0;
                        vox_looping[v] = loop;
                        vox_prio[v] = prio;
                        vox_id[v] = r.new_id;
                        live_voices++;
                        r.vidx = 5'(v);
                    end
                end
            end
            OP_STOP_ID: begin
                v = lookup_id(tgt);
                if (v < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    release_voice(v);
                    r.vidx = 5'(v);
                end
            end
            OP_STOP_ALL: begin
                for (int k = 0; k < VOICES; k++) begin
                    vox_active[k] = 1'b0;
                    vox_finished[k] = 1'b0;
                    vox_id[k] = '0;
                end
                live_voices = '0;
            end
            OP_FINISHED: begin
                if (!vox_active[fin]) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.vidx = fin;
                    if (vox_looping[fin]) begin
                        vox_finished[fin] = 1'b1;
                    end else begin
                        r.done_id = vox_id[fin];
                        release_voice(fin);
                    end
                end
            end
            OP_QUERY: begin
                v = lookup_id(tgt);
                if (v < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.vidx = 5'(v);
                    r.playing = !vox_finished[v];
                end
            end
            default: ;
        endcase
        r.count = live_voices;
        return r;
    endfunction

    function automatic t_stim_row mk_row(input logic [2:0] op, input logic [15:0] vol,
            input logic loop, input logic [9:0] prio, input logic [15:0] tgt,
            input logic [4:0] fin);
        t_stim_row s;
        s.op = op; s.vol = vol; s.loop = loop; s.prio = prio; s.tgt = tgt; s.fin = fin;
        s.typed = 0;
        s.want = '0;
        return s;
    endfunction

    function automatic t_stim_row mk_checked(input t_stim_row s, input logic [1:0] st,
            input logic [15:0] nid, input logic [15:0] gain, input logic [5:0] cnt);
        s.typed = 1;
        s.want = '0;
        s.want.status = st;
        s.want.new_id = nid;
        s.want.gain = gain;
        s.want.count = cnt;
        return s;
    endfunction

    task automatic send_item(input t_stim_row s, input bit may_idle);
        t_outcome r;
        i_operation <= s.op;
        i_volume <= s.vol;
        i_looping <= s.loop;
        i_priority_req <= s.prio;
        i_target_id <= s.tgt;
        i_finished_voice <= s.fin;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        r = allocate_and_predict(s.op, s.vol, s.loop, s.prio, s.tgt, s.fin);
        pending_results.push_back(s.typed ? s.want : r);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MASTER:  master_g = val;
            CFG_MUSIC:   music_g = val;
            CFG_EFFECTS: effects_g = val;
            CFG_SND_EN:  snd_en = val[0];
            CFG_MUS_EN:  mus_en = val[0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_stim_row random_row();
        t_stim_row s;
        int roll;
        logic [2:0] op;
        logic [9:0] prio;
        logic [15:0] tgt;
        roll = $urandom_range(0, 99);
        if (roll < 38) op = OP_PLAY_FX;
        else if (roll < 48) op = OP_PLAY_MUSIC;
        else if (roll < 60) op = OP_STOP_ID;
        else if (roll < 62) op = OP_STOP_ALL;
        else if (roll < 82) op = OP_FINISHED;
        else if (roll < 97) op = OP_QUERY;
        else op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        prio = $urandom_range(0, 1) ? 10'($urandom_range(1000, 1023)) : 10'($urandom);
        tgt = ($urandom_range(0, 3) != 0) ? vox_id[$urandom_range(0, VOICES - 1)]
                                           : 16'($urandom);
        s = mk_row(op, 16'($urandom), 1'($urandom_range(0, 1)), prio, tgt, 5'($urandom));
        return s;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_outcome got, exp_r;
        if (i_rst_n && o_done) begin
            got = {o_status, o_new_id, o_voice_index, o_buffer_index, o_gain,
                   o_is_playing, o_completed_id, o_active_count};
            if (pending_results.size() == 0) begin
                $display("%0t unexpected transaction: actual %h", $time, got);
                failed = 1;
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    $display("%0t mismatch: expected st=%0d id=%0d v=%0d b=%0d g=%0d %s",
                             $time, exp_r.status, exp_r.new_id, exp_r.vidx, exp_r.bidx,
                             exp_r.gain, $sformatf("p=%0d c=%0d n=%0d", exp_r.playing,
                             exp_r.done_id, exp_r.count));
                    $display("%0t          actual   st=%0d id=%0d v=%0d b=%0d g=%0d %s",
                             $time, got.status, got.new_id, got.vidx, got.bidx,
                             got.gain, $sformatf("p=%0d c=%0d n=%0d", got.playing,
                             got.done_id, got.count));
                    failed = 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int v = 0; v < VOICES; v++) begin
            vox_active[v] = 0; vox_finished[v] = 0; vox_looping[v] = 0;
            vox_prio[v] = '0; vox_id[v] = '0;
        end
        id_counter = 16'd1; buf_counter = '0; live_voices = '0;
        master_g = MASTER_RST; music_g = MUSIC_RST; effects_g = EFFECTS_RST;
        snd_en = 1; mus_en = 1;

        dir_tab.push_back(mk_checked(mk_row(OP_QUERY, 0, 0, 0, 16'd0, 0), ST_NOT_FOUND, 0, 0, 0));
        dir_tab.push_back(mk_checked(mk_row(OP_STOP_ID, 0, 0, 0, 16'd5, 0), ST_NOT_FOUND, 0, 0, 0));
        dir_tab.push_back(mk_checked(mk_row(OP_FINISHED, 0, 0, 0, 0, 5'd3), ST_NOT_FOUND, 0, 0, 0));
        dir_tab.push_back(mk_checked(mk_row(OP_PLAY_FX, 16'd32768, 0, 10'd0, 0, 0),
                                     ST_OK, 16'd1, 16'd26214, 6'd1));
        dir_tab.push_back(mk_row(OP_PLAY_MUSIC, 16'hFFFF, 1, 10'd0, 0, 0));
        dir_tab.push_back(mk_row(OP_PLAY_FX, 16'd0, 0, 10'h3FF, 0, 0));
        dir_tab.push_back(mk_row(OP_PLAY_FX, 16'd1, 1, 10'd999, 16'hFFFF, 5'd31));
        dir_tab.push_back(mk_row(OP_QUERY, 0, 0, 0, 16'd2, 0));
        dir_tab.push_back(mk_row(OP_FINISHED, 0, 0, 0, 0, 5'd1));
        dir_tab.push_back(mk_row(OP_QUERY, 0, 0, 0, 16'd2, 0));
        dir_tab.push_back(mk_row(OP_FINISHED, 0, 0, 0, 0, 5'd1));
        dir_tab.push_back(mk_row(OP_PLAY_FX, 16'd16384, 0, 10'd1000, 0, 0));
        dir_tab.push_back(mk_row(OP_FINISHED, 0, 0, 0, 0, 5'd0));
        dir_tab.push_back(mk_row(OP_FINISHED, 0, 0, 0, 0, 5'd31));
        dir_tab.push_back(mk_row(OP_STOP_ID, 0, 0, 0, 16'd3, 0));
        dir_tab.push_back(mk_row(OP_STOP_ID, 0, 0, 0, 16'd0, 0));
        dir_tab.push_back(mk_row(OP_QUERY, 0, 0, 0, 16'd3, 0));
        dir_tab.push_back(mk_row(OP_SPARE_6, 16'hFFFF, 1, 10'h3FF, 16'hFFFF, 5'd31));
        dir_tab.push_back(mk_row(OP_SPARE_7, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(OP_STOP_ALL, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(OP_PLAY_MUSIC, 16'd32769, 0, 10'd5, 0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) send_item(dir_tab[k], 1);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                i_start <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                repeat (5) @(posedge i_clk);
                case (ph)
                    1: begin
                        write_reg(CFG_MASTER, 16'd0); write_reg(CFG_MUSIC, 16'd0);
                        write_reg(CFG_EFFECTS, 16'd0);
                        write_reg(CFG_SND_EN, 16'hFFFF); write_reg(CFG_MUS_EN, 16'hFFFF);
                    end
                    2: begin
                        write_reg(CFG_MASTER, 16'hFFFF); write_reg(CFG_MUSIC, 16'hFFFF);
                        write_reg(CFG_EFFECTS, 16'hFFFF);
                    end
                    3: write_reg(CFG_SND_EN, 16'hFFFE);
                    4: begin
                        write_reg(CFG_SND_EN, 16'd1); write_reg(CFG_MUS_EN, 16'd0);
                    end
                    default: begin
                        write_reg(CFG_MASTER, pick_gain()); write_reg(CFG_MUSIC, pick_gain());
                        write_reg(CFG_EFFECTS, pick_gain());
                        write_reg(CFG_SND_EN, 16'd1);
                        write_reg(CFG_MUS_EN, 16'($urandom_range(0, 3) != 0));
                    end
                endcase
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(random_row(), ph < PHASES - 1 || n < ITEMS_PER_PHASE / 3);
        end
        i_start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/vaps_pkg.sv
rtl/vaps_gain.sv
rtl/voice_allocator_priority_steal.sv
tb/voice_allocator_priority_steal_test.sv
